// ===== hdl/sort_and_duplicate_check_core_defines.svh =====
// Assertion macros shared by the checker of sort_and_duplicate_check_core.
// No dependencies; the including module must provide clk and rst.
`ifndef SORT_AND_DUPLICATE_CHECK_CORE_DEFINES_SVH
`define SORT_AND_DUPLICATE_CHECK_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sdc_pkg.sv =====
// Shared constants, types and control structs for the sort / duplicate check core.
// No dependencies.
package sdc_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SPAN_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [SPAN_W-1:0]            span_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic block_init;
    logic merge_rd;
    logic merge_wr;
    logic out_init;
    logic out_rd;
    logic out_emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sort_more;  // run width still below set size
    logic run_end;    // current merge writes its last word
    logic pass_end;   // current run pair is the last of the pass
    logic out_end;    // current output word is the last
  } sts_t;

endpackage

// ===== hdl/sdc_datapath.sv =====
// Datapath: two ping-pong word banks, merge pointers, compare and flags.
// Depends on sdc_pkg.
module sdc_datapath (
  input  logic          clk,
  input  logic          rst,
  input  sdc_pkg::cmd_t cmd,
  input  sdc_pkg::data_t value,
  output sdc_pkg::sts_t sts,
  output sdc_pkg::data_t sorted_value,
  output logic          final_res,
  output logic          has_duplicate,
  output logic          overflow
);
  import sdc_pkg::*;

  data_t bank0 [CAPACITY];
  data_t bank1 [CAPACITY];
  data_t rd0_a, rd0_b, rd1_a, rd1_b;

  cnt_t  count;
  logic  dropped;
  logic  src;
  logic  dup;
  span_t w;
  span_t lo;
  cnt_t  mid, hi, i, j, k;
  data_t prev;

  span_t n_span, lo_w, lo_2w, w2, mid_c, hi_c;
  data_t a_data, b_data, chosen;
  logic  take_a, full, last_pass, run_end;
  logic  wr0, wr1;
  cnt_t  wr_addr, ra;
  data_t wr_data;

  assign n_span    = {1'b0, count};
  assign w2        = w << 1;
  assign lo_w      = lo + w;
  assign lo_2w     = lo + w2;
  assign mid_c     = (lo_w < n_span) ? lo_w : n_span;
  assign hi_c      = (lo_2w < n_span) ? lo_2w : n_span;
  assign last_pass = (w2 >= n_span);
  assign full      = (count >= CAP_CNT);

  assign a_data  = src ? rd1_a : rd0_a;
  assign b_data  = src ? rd1_b : rd0_b;
  assign take_a  = (i < mid) && ((j >= hi) || (a_data < b_data));
  assign chosen  = take_a ? a_data : b_data;
  assign run_end = ((k + cnt_t'(1)) == hi);

  assign sts.sort_more = (w < n_span);
  assign sts.run_end   = run_end;
  assign sts.pass_end  = (lo_2w >= n_span);
  assign sts.out_end   = (k == (count - cnt_t'(1)));

  // Loading always fills bank 0; a merge writes the bank opposite the source.
  assign wr0     = (cmd.load && !full) || (cmd.merge_wr && src);
  assign wr1     = cmd.merge_wr && !src;
  assign wr_addr = cmd.load ? count : k;
  assign wr_data = cmd.load ? value : chosen;
  assign ra      = cmd.out_rd ? k : i;

  always_ff @(posedge clk) begin
    if (wr0) begin
      bank0[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (wr1) begin
      bank1[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.merge_rd || cmd.out_rd) begin
      rd0_a <= bank0[ra[ADDR_W-1:0]];
      rd0_b <= bank0[j[ADDR_W-1:0]];
      rd1_a <= bank1[ra[ADDR_W-1:0]];
      rd1_b <= bank1[j[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      src     <= 1'b0;
      dup     <= 1'b0;
      w       <= '0;
      lo      <= '0;
      mid     <= '0;
      hi      <= '0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + cnt_t'(1);
        end
      end
      if (cmd.sort_init) begin
        w   <= span_t'(1);
        lo  <= '0;
        src <= 1'b0;
        dup <= 1'b0;
      end
      if (cmd.block_init) begin
        i   <= lo[CNT_W-1:0];
        k   <= lo[CNT_W-1:0];
        mid <= mid_c[CNT_W-1:0];
        j   <= mid_c[CNT_W-1:0];
        hi  <= hi_c[CNT_W-1:0];
      end
      if (cmd.merge_wr) begin
        k <= k + cnt_t'(1);
        if (take_a) begin
          i <= i + cnt_t'(1);
        end else begin
          j <= j + cnt_t'(1);
        end
        // Final pass writes the fully sorted order: equal neighbors show here.
        if (last_pass && (k != '0) && (chosen == prev)) begin
          dup <= 1'b1;
        end
        if (run_end) begin
          if (lo_2w >= n_span) begin
            w   <= w2;
            lo  <= '0;
            src <= ~src;
          end else begin
            lo <= lo_2w;
          end
        end
      end
      if (cmd.out_init) begin
        k <= '0;
      end
      if (cmd.out_emit) begin
        k <= k + cnt_t'(1);
        if (sts.out_end) begin
          count   <= '0;
          dropped <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_wr) begin
      prev <= chosen;
    end
  end

  assign sorted_value  = a_data;
  assign final_res     = sts.out_end;
  assign has_duplicate = dup;
  assign overflow      = dropped;

endmodule

// ===== hdl/sdc_ctrl.sv =====
// Controller state machine: sequences load, merge passes and output burst.
// Depends on sdc_pkg.
module sdc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last,
  input  sdc_pkg::sts_t sts,
  output sdc_pkg::cmd_t cmd,
  output logic          busy,
  output logic          strobe
);
  import sdc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SINIT = 4'd1;
  localparam logic [3:0] S_PASS  = 4'd2;
  localparam logic [3:0] S_BLOCK = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MWR   = 4'd5;
  localparam logic [3:0] S_OINIT = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OEM   = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start && last) state_next = S_SINIT;
      S_SINIT: state_next = S_PASS;
      S_PASS:  state_next = sts.sort_more ? S_BLOCK : S_OINIT;
      S_BLOCK: state_next = S_MRD;
      S_MRD:   state_next = S_MWR;
      S_MWR: begin
        if (!sts.run_end) begin
          state_next = S_MRD;
        end else if (sts.pass_end) begin
          state_next = S_PASS;
        end else begin
          state_next = S_BLOCK;
        end
      end
      S_OINIT: state_next = S_ORD;
      S_ORD:   state_next = S_OEM;
      S_OEM:   state_next = sts.out_end ? S_IDLE : S_ORD;
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd.load       = (state == S_IDLE) && start;
  assign cmd.sort_init  = (state == S_SINIT);
  assign cmd.block_init = (state == S_BLOCK);
  assign cmd.merge_rd   = (state == S_MRD);
  assign cmd.merge_wr   = (state == S_MWR);
  assign cmd.out_init   = (state == S_OINIT);
  assign cmd.out_rd     = (state == S_ORD);
  assign cmd.out_emit   = (state == S_OEM);

  assign busy   = (state != S_IDLE);
  assign strobe = (state == S_OEM);

endmodule

// ===== hdl/sort_and_duplicate_check_core.sv =====
// Top level of the sort / duplicate check core: controller plus datapath.
// Depends on sdc_pkg, sdc_ctrl, sdc_datapath.
//
// Usage:
//  - Input: a word (value, last) is taken on a rising edge with start high
//    and busy low. Words without last are stored and the core stays idle
//    (busy low), so a set loads at one word per cycle.
//  - Up to CAPACITY words are kept; further words are dropped and the
//    overflow flag is raised for the whole output burst of that set.
//  - The word with last set ends the set; busy rises on the next cycle and
//    the stored words are merge sorted in bank-to-bank passes.
//  - Sort steps for n words: each pass gives every word a registered bank
//    read, then a compare and write; each run pair adds a setup step and
//    each pass a pass check; ceil(log2 n) passes follow a start step.
//    The shared pair of bank read ports sets this read-then-write order.
//  - Output: after output setup the n sorted words leave in ascending
//    order, each read from the bank, then marked by a one-cycle strobe;
//    final_res marks the last one. has_duplicate and overflow hold for the
//    whole burst. The receiver cannot stall: each word is taken in its cycle.
//  - busy drops the cycle after the last strobe; the core then takes a new set.
//  - Reset (rst, synchronous) returns to idle with an empty set; bank contents
//    are not cleared and need no clearing.
module sort_and_duplicate_check_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdc_pkg::data_t value,
  input  logic           last,
  output logic           strobe,
  output sdc_pkg::data_t sorted_value,
  output logic           final_res,
  output logic           has_duplicate,
  output logic           overflow
);
  import sdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  sdc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .sts           (sts),
    .sorted_value  (sorted_value),
    .final_res     (final_res),
    .has_duplicate (has_duplicate),
    .overflow      (overflow)
  );

endmodule

// ===== hdl/sdc_checker.sv =====
// Port-level checker for sort_and_duplicate_check_core, attached by bind.
// Depends on sort_and_duplicate_check_core_defines.svh.
`include "sort_and_duplicate_check_core_defines.svh"

module sdc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic strobe,
  input logic final_res
);

  `SDC_ASSERT_NOW(a_strobe_busy, strobe, busy, "result strobe while idle")
  `SDC_ASSERT_NEXT(a_strobe_gap, strobe, !strobe, "back-to-back result strobes")
  `SDC_ASSERT_NEXT(a_final_idle, strobe && final_res, !busy, "busy after final word")
  `SDC_ASSERT_NEXT(a_burst_busy, strobe && !final_res, busy, "burst ended early")
  `SDC_ASSERT_NEXT(a_load_idle, start && !busy && !last, !busy, "busy after plain load")

endmodule

bind sort_and_duplicate_check_core sdc_checker u_sdc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last      (last),
  .strobe    (strobe),
  .final_res (final_res)
);
